// File: hdl/lbe_pkg.sv
package lbe_pkg;

  localparam int unsigned ValW  = 32;
  localparam int unsigned DivW  = 64;
  localparam int unsigned DvsW  = 33;
  localparam int unsigned StepW = 25;

  localparam logic signed [ValW-1:0] QOne = 32'sh0100_0000;
  localparam logic signed [ValW-1:0] QMax = 32'sh7fff_ffff;
  localparam logic signed [ValW-1:0] QMin = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_EVAL  = 2'd1,
    CMD_DERIV = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_ZERO = 2'd1,
    STAT_IDX  = 2'd2,
    STAT_SAT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_NODE_COUNT  = 2'd0,
    REG_BASIS_INDEX = 2'd1,
    REG_STEP_SIZE   = 2'd2,
    REG_NONE        = 2'd3
  } reg_e;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic                   sat;
  } sq_t;

  // signed result from magnitude and sign, clamped to Q8.24
  function automatic sq_t signed_quot(logic [DivW-1:0] mag, logic neg);
    sq_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.value = QMin;
        r.sat   = 1'b1;
      end else begin
        r.value = ValW'(-mag);
      end
    end else begin
      if (mag > 64'h7fff_ffff) begin
        r.value = QMax;
        r.sat   = 1'b1;
      end else begin
        r.value = ValW'(mag);
      end
    end
    return r;
  endfunction

endpackage

// File: hdl/lbe_in_if.sv
interface lbe_in_if;
  import lbe_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [3:0]        node_index;
  logic signed [31:0] node_value;
  logic signed [31:0] point;
  modport source (output valid, cmd, node_index, node_value, point, input ready);
  modport sink   (input valid, cmd, node_index, node_value, point, output ready);
endinterface

// File: hdl/lbe_out_if.sv
interface lbe_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [1:0]         status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

// File: hdl/lbe_cfg_if.sv
interface lbe_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/lbe_node_table.sv
module lbe_node_table
  import lbe_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16,
  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
  input  logic                   clk_i,
  input  logic                   wr_en_i,
  input  logic [IdxW-1:0]        wr_idx_i,
  input  logic signed [ValW-1:0] wr_data_i,
  input  logic [IdxW-1:0]        rd_idx_i,
  output logic signed [ValW-1:0] rd_data_o
);

  logic signed [ValW-1:0] mem_q [MAX_NODES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_idx_i];

endmodule

// File: hdl/lbe_divider.sv
module lbe_divider
  import lbe_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivW);

  logic [DvsW-1:0] rem_q, rem_d;
  logic [DvsW-1:0] dvs_q;
  logic [DivW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DvsW:0]   rem_sh;
  logic [DvsW:0]   diff;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_q, quo_q[DivW-1]};
    diff   = rem_sh - {1'b0, dvs_q};
    if (!diff[DvsW]) begin
      rem_d = diff[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[DvsW-1:0];
      quo_d = {quo_q[DivW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW - 1);
        rem_q  <= '0;
        quo_q  <= dividend_i;
        dvs_q  <= divisor_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= quo_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a pass");
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> rem_q < dvs_q)
    else $error("remainder not below divisor");

endmodule

// File: hdl/lagrange_basis_evaluator.sv
// Lagrange basis evaluator, signed Q8.24. Load items (cmd 0) write a node when
// accepted. An evaluate item (cmd 1) checks the nodes, then for each of the n-1
// factors forms and multiplies operands and divides in the shared bit-serial
// divider. A derivative item (cmd 2) runs that product four times plus one
// final division. The input is not ready during that work; a finished item
// waits in the output register while the next is accepted.
// Configuration writes are taken at any time but belong between items.
module lagrange_basis_evaluator
  import lbe_pkg::*;
#(
  parameter int unsigned MAX_NODES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lbe_in_if.sink    in_i,
  lbe_out_if.source out_o,
  lbe_cfg_if.sink   cfg_i
);

  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned CntW = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CHKK, S_CHK, S_PREP, S_FACT, S_MUL, S_DSTART, S_DIVW, S_SUM, S_FIN
  } state_e;

  state_e st_q;

  logic [4:0]        node_count_q;
  logic [3:0]        basis_q;
  logic [StepW-1:0]  step_q;

  logic                   deriv_q, final_q, sat_q, neg_q;
  logic [1:0]             err_q;
  logic signed [ValW-1:0] x_q, xk_q, cx_q, p_q, val_q;
  logic signed [ValW-1:0] f_q [4];
  logic [3:0]             k_q;
  logic [CntW-1:0]        n_q, j_q;
  logic [1:0]             pi_q;
  logic [31:0]            mp_q;
  logic [32:0]            mn_q;
  logic [DvsW-1:0]        dvs_q;
  logic [DivW-1:0]        prod_q;
  logic                   out_valid_q;
  logic signed [ValW-1:0] out_value_q;
  logic [1:0]             out_status_q;

  // table
  logic                   wr_en;
  logic [IdxW-1:0]        rd_idx;
  logic signed [ValW-1:0] rd_data;

  // divider
  logic            div_start, div_busy, div_done;
  logic [DivW-1:0] div_quot;
  sq_t             dq;

  logic            in_acc;
  logic [CntW-1:0] n_clamp;
  logic signed [33:0] off, xsum;
  logic signed [32:0] num, den;
  logic [33:0]        num_mag;
  logic [32:0]        den_mag, p_mag;
  logic signed [36:0] ssum;
  logic [36:0]        s_mag;
  logic [28:0]        h12;
  logic               out_free;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free   = !out_valid_q || out_o.ready;

  always_comb begin
    if (node_count_q < 5'd2) begin
      n_clamp = CntW'(2);
    end else if (32'(node_count_q) > MAX_NODES) begin
      n_clamp = CntW'(MAX_NODES);
    end else begin
      n_clamp = CntW'(node_count_q);
    end
  end

  assign wr_en  = in_acc && (in_i.cmd == CMD_LOAD) && (32'(in_i.node_index) < MAX_NODES);
  assign rd_idx = (st_q == S_CHKK) ? IdxW'(k_q) : j_q[IdxW-1:0];

  lbe_node_table #(.MAX_NODES(MAX_NODES)) u_table (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_idx_i (IdxW'(in_i.node_index)),
    .wr_data_i(in_i.node_value),
    .rd_idx_i (rd_idx),
    .rd_data_o(rd_data)
  );

  assign div_start = (st_q == S_DSTART);

  lbe_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(prod_q),
    .divisor_i (dvs_q),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  assign dq = signed_quot(div_quot, neg_q);

  // shifted evaluation point: +2h, +h, -h, -2h for derivatives, none otherwise
  always_comb begin
    unique case (pi_q)
      2'd0:    off = 34'(step_q) <<< 1;
      2'd1:    off = 34'(step_q);
      2'd2:    off = -34'(step_q);
      default: off = -(34'(step_q) <<< 1);
    endcase
    if (!deriv_q) begin
      off = '0;
    end
    xsum = 34'(x_q) + off;
  end

  always_comb begin
    num     = 33'(cx_q) - 33'(rd_data);
    den     = 33'(xk_q) - 33'(rd_data);
    num_mag = num[32] ? 34'(-34'(num)) : 34'(34'(num));
    den_mag = den[32] ? 33'(-den) : 33'(den);
    p_mag   = p_q[31] ? 33'(-33'(p_q)) : 33'(33'(p_q));
    ssum    = -37'(f_q[0]) + (37'(f_q[1]) <<< 3) - (37'(f_q[2]) <<< 3) + 37'(f_q[3]);
    s_mag   = ssum[36] ? 37'(-ssum) : 37'(ssum);
    h12     = (29'(step_q) << 3) + (29'(step_q) << 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= S_IDLE;
      node_count_q <= 5'd2;
      basis_q      <= 4'd0;
      step_q       <= 25'd16777;
      deriv_q      <= 1'b0;
      final_q      <= 1'b0;
      sat_q        <= 1'b0;
      neg_q        <= 1'b0;
      err_q        <= STAT_OK;
      x_q          <= '0;
      xk_q         <= '0;
      cx_q         <= '0;
      p_q          <= '0;
      val_q        <= '0;
      f_q          <= '{default: '0};
      k_q          <= '0;
      n_q          <= '0;
      j_q          <= '0;
      pi_q         <= '0;
      mp_q         <= '0;
      mn_q         <= '0;
      dvs_q        <= '0;
      prod_q       <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= STAT_OK;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          REG_NODE_COUNT:  node_count_q <= cfg_i.data[4:0];
          REG_BASIS_INDEX: basis_q      <= cfg_i.data[3:0];
          REG_STEP_SIZE:   step_q       <= cfg_i.data[StepW-1:0];
          default: ;
        endcase
      end
      if (st_q == S_FIN && out_free) begin
        out_valid_q  <= 1'b1;
        out_value_q  <= val_q;
        out_status_q <= (err_q != STAT_OK) ? err_q : (sat_q ? STAT_SAT : STAT_OK);
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (st_q)
        S_IDLE: begin
          if (in_acc && (in_i.cmd == CMD_EVAL || in_i.cmd == CMD_DERIV)) begin
            deriv_q <= (in_i.cmd == CMD_DERIV);
            x_q     <= in_i.point;
            k_q     <= basis_q;
            n_q     <= n_clamp;
            sat_q   <= 1'b0;
            final_q <= 1'b0;
            val_q   <= '0;
            pi_q    <= '0;
            if (32'(basis_q) >= 32'(n_clamp)) begin
              err_q <= STAT_IDX;
              st_q  <= S_FIN;
            end else begin
              err_q <= STAT_OK;
              st_q  <= S_CHKK;
            end
          end
        end
        S_CHKK: begin
          xk_q <= rd_data;
          j_q  <= '0;
          st_q <= S_CHK;
        end
        S_CHK: begin
          if (j_q == n_q) begin
            if (deriv_q && step_q == '0) begin
              err_q <= STAT_ZERO;
              st_q  <= S_FIN;
            end else begin
              st_q <= S_PREP;
            end
          end else if (32'(j_q) != 32'(k_q) && rd_data == xk_q) begin
            err_q <= STAT_ZERO;
            st_q  <= S_FIN;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        S_PREP: begin
          if (xsum > 34'(QMax)) begin
            cx_q  <= QMax;
            sat_q <= 1'b1;
          end else if (xsum < 34'(QMin)) begin
            cx_q  <= QMin;
            sat_q <= 1'b1;
          end else begin
            cx_q <= ValW'(xsum);
          end
          p_q  <= QOne;
          j_q  <= '0;
          st_q <= S_FACT;
        end
        S_FACT: begin
          if (j_q == n_q) begin
            if (!deriv_q) begin
              val_q <= p_q;
              st_q  <= S_FIN;
            end else begin
              f_q[pi_q] <= p_q;
              if (pi_q == 2'd3) begin
                st_q <= S_SUM;
              end else begin
                pi_q <= pi_q + 1'b1;
                st_q <= S_PREP;
              end
            end
          end else if (32'(j_q) == 32'(k_q)) begin
            j_q <= j_q + 1'b1;
          end else begin
            mp_q  <= p_mag[31:0];
            mn_q  <= num_mag[32:0];
            dvs_q <= den_mag;
            neg_q <= p_q[31] ^ num[32] ^ den[32];
            st_q  <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q <= {32'd0, mp_q} * {31'd0, mn_q};
          st_q   <= S_DSTART;
        end
        S_DSTART: begin
          st_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            sat_q <= sat_q | dq.sat;
            if (final_q) begin
              val_q <= dq.value;
              st_q  <= S_FIN;
            end else begin
              p_q  <= dq.value;
              j_q  <= j_q + 1'b1;
              st_q <= S_FACT;
            end
          end
        end
        S_SUM: begin
          prod_q  <= DivW'(s_mag) << 24;
          dvs_q   <= DvsW'(h12);
          neg_q   <= ssum[36];
          final_q <= 1'b1;
          st_q    <= S_DSTART;
        end
        S_FIN: begin
          if (out_free) begin
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.value  = out_value_q;
  assign out_o.status = out_status_q;

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !div_busy)
    else $error("divider busy while idle");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == STAT_ZERO || out_o.status == STAT_IDX)
      |-> out_o.value == '0)
    else $error("error item carries a value");
  a_fin_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_FIN && out_free |=> out_o.valid && st_q == S_IDLE)
    else $error("finished item not presented");

endmodule
